[rtl/bsim_pkg.sv]
// ----------------------------------------------------------------------------
// bsim_pkg: shared types and constants for the Bresenham scale index map
// Field widths, register indexes, run state and map write word layout.
// ----------------------------------------------------------------------------
package bsim_pkg;

  localparam int LEN_W = 13;  // line lengths, positions, step counts
  localparam int IDX_W = 12;  // map table index width
  localparam int DEC_W = 15;  // signed decision term and its increments
  localparam int CFG_W = 1;   // register index width

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(4096);

  // Register indexes on the configuration port
  localparam logic [CFG_W-1:0] REG_SOURCE_LENGTH = 1'b0;
  localparam logic [CFG_W-1:0] REG_DEST_LENGTH   = 1'b1;

  typedef logic [LEN_W-1:0]        len_t;
  typedef logic signed [DEC_W-1:0] dec_t;

  // Latched run parameters plus the live Bresenham state
  typedef struct packed {
    logic running;
    logic shrink;
    len_t run_steps;
    len_t steps_done;
    len_t dest_position;
    len_t source_position;
    dec_t decision;
    dec_t inc_straight;
    dec_t inc_diag;
  } run_state_t;

  typedef struct packed {
    logic             write_enable;
    logic [IDX_W-1:0] dest_index;
    logic [IDX_W-1:0] source_index;
    logic             last;
  } map_write_t;

  function automatic len_t clamp_len(input len_t v);
    return (v > MAX_LEN) ? MAX_LEN : v;
  endfunction

endpackage

[rtl/bsim_step_if.sv]
// ----------------------------------------------------------------------------
// bsim_step_if: step request channel
// Valid/ready channel carrying one step request per word.
// ----------------------------------------------------------------------------
interface bsim_step_if;
  logic valid;
  logic ready;
  logic first;

  modport source (output valid, output first, input ready);
  modport sink   (input valid, input first, output ready);
endinterface

[rtl/bsim_write_if.sv]
// ----------------------------------------------------------------------------
// bsim_write_if: map write channel
// Valid/ready channel carrying one map table write per word.
// ----------------------------------------------------------------------------
interface bsim_write_if;
  logic                     valid;
  logic                     ready;
  logic                     write_enable;
  logic [bsim_pkg::IDX_W-1:0] dest_index;
  logic [bsim_pkg::IDX_W-1:0] source_index;
  logic                     last;

  modport source (output valid, output write_enable, output dest_index,
                  output source_index, output last, input ready);
  modport sink   (input valid, input write_enable, input dest_index,
                  input source_index, input last, output ready);
endinterface

[rtl/bsim_step.sv]
// ----------------------------------------------------------------------------
// bsim_step: one Bresenham step
// Restarts the run on first (or stops it if a length is zero), emits the map write and advances the state.
// ----------------------------------------------------------------------------
module bsim_step (
  input  logic                 first,
  input  bsim_pkg::len_t       source_length,
  input  bsim_pkg::len_t       dest_length,
  input  bsim_pkg::run_state_t cur,
  output bsim_pkg::run_state_t nxt,
  output bsim_pkg::map_write_t result
);
  import bsim_pkg::*;

  len_t       src;
  len_t       dst;
  len_t       major;
  len_t       minor;
  run_state_t st;
  logic       last;

  always_comb begin
    src   = clamp_len(source_length);
    dst   = clamp_len(dest_length);
    major = (dst < src) ? src : dst;
    minor = (dst < src) ? dst : src;

    st = cur;
    if (first) begin
      st.running = 1'b0;
      if (src != '0 && dst != '0) begin
        st.shrink          = dst < src;
        st.inc_straight    = $signed({1'b0, minor, 1'b0}) - dec_t'(1);
        st.decision        = st.inc_straight - $signed({2'b00, major});
        st.inc_diag        = st.decision - $signed({2'b00, major});
        st.run_steps       = major;
        st.steps_done      = '0;
        st.dest_position   = '0;
        st.source_position = '0;
        st.running         = 1'b1;
      end
    end

    last   = ({1'b0, st.steps_done} + (LEN_W+1)'(1)) >= {1'b0, st.run_steps};
    result = '0;
    nxt    = st;
    if (st.running) begin
      result.write_enable = 1'b1;
      result.dest_index   = st.dest_position[IDX_W-1:0];
      result.source_index = st.source_position[IDX_W-1:0];
      result.last         = last;

      if (st.decision < 0) begin
        // straight step: advance the major axis only
        if (st.shrink) begin
          nxt.source_position = st.source_position + LEN_W'(1);
        end else begin
          nxt.dest_position = st.dest_position + LEN_W'(1);
        end
        nxt.decision = st.decision + st.inc_straight;
      end else begin
        nxt.dest_position   = st.dest_position + LEN_W'(1);
        nxt.source_position = st.source_position + LEN_W'(1);
        nxt.decision        = st.decision + st.inc_diag;
      end
      nxt.steps_done = st.steps_done + LEN_W'(1);
      if (last) begin
        nxt.running = 1'b0;
      end
    end
  end

endmodule

[rtl/bresenham_scale_index_map.sv]
// ----------------------------------------------------------------------------
// bresenham_scale_index_map: nearest-neighbor scaling index map generator
// Each step word yields one map write word from Bresenham stepping.
// ----------------------------------------------------------------------------
//
// Channel     Dir  Word contents
// step        in   first (restart the run from the length registers)
// map_write   out  write_enable, dest_index, source_index, last
// cfg_*       in   cfg_we, cfg_index (0 source_length, 1 dest_length), cfg_data
//
// One step word is taken every cycle unless stalled; its map write word appears in the
// output register on the next cycle. The only stored stage is that output
// register, so throughput is one word per clock while not stalled.
// Stall: step.ready drops only while a map write word is held unaccepted.
// Reset (rst, synchronous) clears both lengths, the run state and the
// output valid; the block then issues no map table writes until a step word with first.
//
module bresenham_scale_index_map (
  input  logic                          clk,
  input  logic                          rst,
  bsim_step_if.sink                     step,
  bsim_write_if.source                  map_write,
  input  logic                          cfg_we,
  input  logic [bsim_pkg::CFG_W-1:0]    cfg_index,
  input  logic [bsim_pkg::LEN_W-1:0]    cfg_data
);
  import bsim_pkg::*;

  len_t       source_length;
  len_t       dest_length;
  run_state_t run_state;
  run_state_t run_state_next;
  map_write_t result;
  map_write_t result_next;
  logic       out_valid;
  logic       step_take;

  // Length registers; a write only matters at the next restart.
  always_ff @(posedge clk) begin
    if (rst) begin
      source_length <= '0;
      dest_length   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SOURCE_LENGTH: source_length <= cfg_data;
        REG_DEST_LENGTH:   dest_length   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Accept a new step whenever the output register is free or draining.
  assign step.ready = !out_valid || map_write.ready;
  assign step_take  = step.valid && step.ready;

  bsim_step u_step (
    .first         (step.first),
    .source_length (source_length),
    .dest_length   (dest_length),
    .cur           (run_state),
    .nxt           (run_state_next),
    .result        (result_next)
  );

  // Advance the run state on every accepted step word.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_state <= '0;
    end else if (step_take) begin
      run_state <= run_state_next;
    end
  end

  // Output register: load on accept, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_take) begin
      out_valid <= 1'b1;
    end else if (map_write.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_take) begin
      result <= result_next;
    end
  end

  assign map_write.valid        = out_valid;
  assign map_write.write_enable = result.write_enable;
  assign map_write.dest_index   = result.dest_index;
  assign map_write.source_index = result.source_index;
  assign map_write.last         = result.last;

endmodule
